>>> rtl/srb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_pkg: shared types and constants for the spline reweight unit
// Holds the beat formats and the sequencer states.
// ----------------------------------------------------------------------------
package srb_pkg;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_SHIFT = 2'd1;
	localparam logic [1:0] KIND_BIN   = 2'd2;
	localparam logic [1:0] KIND_RSVD  = 2'd3;

	localparam logic [2:0] CFG_NUM_POINTS  = 3'd0;
	localparam logic [2:0] CFG_FIRST_SHIFT = 3'd1;
	localparam logic [2:0] CFG_SPLIT       = 3'd2;

	localparam int unsigned MAX_SYSTS      = 16;
	localparam int unsigned MAX_BINS       = 64;
	localparam int unsigned MAX_POINTS     = 8;
	localparam int unsigned NUM_COMPONENTS = 5;
	localparam logic [15:0] RATIO_CAP = 16'd32768;

	typedef struct packed {
		logic [1:0]         kind;
		logic [3:0]         syst_index;
		logic [2:0]         component;
		logic               antineutrino;
		logic [5:0]         bin_index;
		logic [2:0]         point_index;
		logic [15:0]        sample_ratio;
		logic signed [15:0] shift_value;
		logic [31:0]        nominal_value;
	} srb_in_t;

	typedef struct packed {
		logic [31:0] shifted_value;
		logic [5:0]  out_bin_index;
		logic        saturated;
	} srb_out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_RD, ST_RDW, ST_COEF, ST_H1, ST_H2, ST_H3,
		ST_VAL, ST_PROD, ST_SCALE, ST_OUT
	} srb_state_t;

endpackage

>>> rtl/spline_reweight_bins_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spline_reweight_bins_unit: per-bin cubic spline reweighting
// The next beat after a bin request is taken in the cycle after the result
// registers, later while a stalled result waits. Load and shift beats are
// applied in idle. One shared multiplier does the Horner steps, product and
// scaling. Reset clears shifts, state and valid and sets the default config;
// sample memory is undefined until loaded.
// ----------------------------------------------------------------------------
module spline_reweight_bins_unit
	import srb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [2:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  srb_in_t    in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output srb_out_t   out_data
);

	localparam int SW = (MAX_SYSTS > 1) ? $clog2(MAX_SYSTS) : 1;
	localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int PW = $clog2(MAX_POINTS);
	localparam int CW = 3;
	localparam int AW = SW + CW + 1 + BW + PW;
	localparam int DEPTH = MAX_SYSTS * 8 * 2 * MAX_BINS * MAX_POINTS;

	logic [15:0] mem [DEPTH];
	logic signed [15:0] shift_q [MAX_SYSTS];
	logic [2:0] npts_q;
	logic signed [2:0] first_q;
	logic split_q;

	srb_state_t state_q, state_d;
	srb_in_t req_q;
	logic [SW:0] s_q;
	logic [2:0] k_q;
	logic [15:0] y_q [4];
	logic [15:0] rd_q;
	logic [3:0] seg_q;
	logic signed [16:0] dx_q;
	logic signed [63:0] acc_q;
	logic signed [23:0] corr_q;
	logic sat_q;
	logic [63:0] res_q;
	logic ov_q;
	srb_out_t od_q;

	logic [3:0] nclamp;
	always_comb begin
		nclamp = {1'b0, npts_q};
		if (nclamp < 4'd2) nclamp = 4'd2;
		if (nclamp > 4'(MAX_POINTS)) nclamp = 4'(MAX_POINTS);
	end

	logic [CW-1:0] comp_c;
	assign comp_c = (req_q.component >= 3'(NUM_COMPONENTS)) ? 3'(NUM_COMPONENTS - 1)
		: req_q.component;

	logic ld_ok;
	assign ld_ok = ({1'b0, in_data.syst_index} < 5'(MAX_SYSTS))
		&& ({1'b0, in_data.bin_index} < 7'(MAX_BINS))
		&& ({1'b0, in_data.point_index} < 4'(MAX_POINTS));

	logic [SW-1:0] s_idx;
	assign s_idx = s_q[SW-1:0];
	logic signed [15:0] cur_shift;
	assign cur_shift = shift_q[s_idx];

	// segment
	logic signed [18:0] dd;
	logic [6:0] sg;
	logic [3:0] seg_c;
	always_comb begin
		dd = 19'(cur_shift) - 19'(signed'(first_q)) * 19'sd4096;
		sg = dd[18] ? 7'd0 : 7'(dd[18:12]);
		seg_c = (sg > 7'(nclamp - 4'd2)) ? (nclamp - 4'd2) : sg[3:0];
	end

	// point to read at step k
	logic [3:0] base, pidx;
	logic bin_ok;
	assign base = (nclamp == 4'd2 || seg_q == 4'd0) ? 4'd0 : seg_q - 4'd1;
	assign pidx = base + {2'b0, k_q[1:0]};
	assign bin_ok = {1'b0, req_q.bin_index} < 7'(MAX_BINS);
	logic g;
	assign g = split_q ? req_q.antineutrino : 1'b0;
	logic [AW-1:0] raddr, waddr;
	assign raddr = {s_idx, comp_c, g, req_q.bin_index[BW-1:0], pidx[PW-1:0]};
	logic [CW-1:0] wcomp;
	assign wcomp = (in_data.component >= 3'(NUM_COMPONENTS)) ? 3'(NUM_COMPONENTS - 1)
		: in_data.component;
	assign waddr = {in_data.syst_index[SW-1:0], wcomp, in_data.antineutrino,
		in_data.bin_index[BW-1:0], in_data.point_index[PW-1:0]};

	logic acc_in;
	assign acc_in = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (acc_in && in_data.kind == KIND_LOAD && ld_ok)
			mem[waddr] <= (in_data.sample_ratio > RATIO_CAP) ? RATIO_CAP
				: in_data.sample_ratio;
		rd_q <= mem[raddr];
	end

	// coefficients (doubled)
	logic signed [19:0] y0, y1, y2, y3, cA, cB, cC, cD;
	always_comb begin
		y0 = 20'(y_q[0]); y1 = 20'(y_q[1]); y2 = 20'(y_q[2]); y3 = 20'(y_q[3]);
		cA = '0; cB = '0;
		if (nclamp == 4'd2) begin
			cC = 20'sd2 * (y1 - y0); cD = 20'sd2 * y0;
		end else if (seg_q == 4'd0) begin
			cB = y0 - 20'sd2 * y1 + y2; cC = -20'sd3 * y0 + 20'sd4 * y1 - y2;
			cD = 20'sd2 * y0;
		end else if (seg_q == nclamp - 4'd2) begin
			cB = y0 - 20'sd2 * y1 + y2; cC = y2 - y0; cD = 20'sd2 * y1;
		end else begin
			cA = -y0 + 20'sd3 * y1 - 20'sd3 * y2 + y3;
			cB = 20'sd2 * y0 - 20'sd5 * y1 + 20'sd4 * y2 - y3;
			cC = y2 - y0; cD = 20'sd2 * y1;
		end
	end

	// shared multiplier
	logic signed [33:0] ma, mb;
	logic signed [67:0] mp;
	always_comb begin
		ma = 34'(acc_q[33:0]);
		mb = 34'(dx_q);
		case (state_q)
			ST_PROD:  begin ma = 34'(corr_q); mb = 34'(acc_q[33:0]); end
			ST_SCALE: begin ma = {2'b0, req_q.nominal_value}; mb = 34'(corr_q); end
			default:  ;
		endcase
		mp = ma * mb;
	end
	logic signed [63:0] hsh;
	assign hsh = 64'(mp >>> 12);

	logic signed [63:0] v2;
	logic vs;
	logic signed [23:0] vcl;
	always_comb begin
		v2 = acc_q <<< 1;
		vs = (v2 > 64'sd8388607) || (v2 < -64'sd8388608);
		vcl = (v2 > 64'sd8388607) ? 24'sd8388607 :
			(v2 < -64'sd8388608) ? -24'sd8388608 : 24'(v2);
	end
	logic signed [51:0] p16;
	logic ps;
	logic signed [23:0] pcl;
	always_comb begin
		p16 = 52'(mp >>> 16);
		ps = (p16 > 52'sd8388607) || (p16 < -52'sd8388608);
		pcl = (p16 > 52'sd8388607) ? 24'sd8388607 :
			(p16 < -52'sd8388608) ? -24'sd8388608 : 24'(p16);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (acc_in && in_data.kind == KIND_BIN) state_d = ST_SCAN;
			ST_SCAN:
				if (s_q == (SW+1)'(MAX_SYSTS)) state_d = ST_SCALE;
				else if (cur_shift != 16'sd0) state_d = ST_RD;
			ST_RD:    state_d = ST_RDW;
			ST_RDW:   state_d = (k_q == 3'd4) ? ST_COEF : ST_RD;
			ST_COEF:  state_d = ST_H1;
			ST_H1:    state_d = ST_H2;
			ST_H2:    state_d = ST_H3;
			ST_H3:    state_d = ST_VAL;
			ST_VAL:   state_d = ST_PROD;
			ST_PROD:  state_d = ST_SCAN;
			ST_SCALE: state_d = ST_OUT;
			ST_OUT:   if (!out_valid || !out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = ov_q;
	assign out_data = od_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			npts_q  <= 3'd7;
			first_q <= -3'sd3;
			split_q <= 1'b0;
			ov_q    <= 1'b0;
			for (int i = 0; i < MAX_SYSTS; i++) shift_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_NUM_POINTS:  npts_q <= cfg_data;
					CFG_FIRST_SHIFT: first_q <= signed'(cfg_data);
					CFG_SPLIT:       split_q <= cfg_data[0];
					default:         ;
				endcase
			end
			if (acc_in && in_data.kind == KIND_SHIFT
				&& {1'b0, in_data.syst_index} < 5'(MAX_SYSTS))
				shift_q[in_data.syst_index[SW-1:0]] <= in_data.shift_value;
			if (state_q == ST_OUT && (!ov_q || !out_stall)) ov_q <= 1'b1;
			else if (ov_q && !out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q <= in_data; s_q <= '0; corr_q <= 24'sd65536; sat_q <= 1'b0;
			end
			ST_SCAN:
				if (s_q != (SW+1)'(MAX_SYSTS) && cur_shift != 16'sd0) begin
					seg_q <= seg_c;
					dx_q <= 17'(cur_shift) - (17'(signed'(first_q)) + 17'(seg_c)) * 17'sd4096;
					k_q <= 3'd0;
				end else if (s_q != (SW+1)'(MAX_SYSTS)) s_q <= s_q + 1'b1;
			ST_RD: k_q <= k_q + 3'd1;
			ST_RDW: y_q[k_q[1:0] - 2'd1] <= (bin_ok && pidx <= 4'(MAX_POINTS)) ? rd_q : 16'd0;
			ST_COEF: acc_q <= 64'(cA);
			ST_H1: acc_q <= hsh + 64'(cB);
			ST_H2: acc_q <= hsh + 64'(cC);
			ST_H3: acc_q <= hsh + 64'(cD);
			ST_VAL: begin acc_q <= 64'(vcl); sat_q <= sat_q | vs; end
			ST_PROD: begin
				corr_q <= pcl; sat_q <= sat_q | ps; s_q <= s_q + 1'b1;
			end
			ST_SCALE: res_q <= corr_q[23] ? 64'd0 : 64'(mp >>> 16);
			ST_OUT:
				if (!ov_q || !out_stall) begin
					od_q.shifted_value <= (res_q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : res_q[31:0];
					od_q.out_bin_index <= req_q.bin_index;
					od_q.saturated <= sat_q | (res_q > 64'hFFFFFFFF);
				end
			default: ;
		endcase
	end

endmodule

>>> tb/sv/tb_spline_reweight_bins_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spline_reweight_bins_unit: self-checking bench for the spline reweight unit
// Loads ratio tables, sets shifts and requests bins under several point-count,
// origin and sign-split settings, with random idle and stall on both sides.
// Every bin result is compared against an in-bench fixed-point spline predictor.
// ----------------------------------------------------------------------------
module tb_spline_reweight_bins_unit;
	import srb_pkg::*;

	localparam int NSYST = 16;
	localparam int NBIN  = 64;
	localparam int NPT   = 8;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [2:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	srb_in_t    in_data;
	logic       out_valid;
	logic       out_stall;
	srb_out_t   out_data;

	spline_reweight_bins_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data)
	);

	// predictor state
	logic [15:0]        ratio_tab [NSYST][NUM_COMPONENTS][2][NBIN][NPT];
	bit                 ratio_set [NSYST][NUM_COMPONENTS][2][NBIN][NPT];
	logic signed [15:0] shift_tab [NSYST];
	int                 pt_count;
	int                 origin;
	bit                 by_sign;

	srb_out_t expected_bins[$];
	int       mismatches;
	int       bins_checked;
	int       items_sent;
	int       idle_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("timeout");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic longint fshr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint clampq(longint v, ref bit sat);
		if (v > 64'sd8388607) begin
			sat = 1;
			return 8388607;
		end
		if (v < -64'sd8388608) begin
			sat = 1;
			return -8388608;
		end
		return v;
	endfunction

	function automatic longint smp(int s, int c, int g, int b, int p);
		return longint'(ratio_tab[s][c][g][b][p]);
	endfunction

	function automatic srb_out_t predict_bin(srb_in_t it);
		srb_out_t r;
		int n, c, g, b, seg;
		longint x, d, dx, A, B, C, D, acc, v, corr, y0, y1, y2, y3;
		logic [63:0] res;
		bit sat;
		n = pt_count < 2 ? 2 : (pt_count > NPT ? NPT : pt_count);
		c = it.component >= NUM_COMPONENTS ? NUM_COMPONENTS - 1 : it.component;
		g = by_sign ? it.antineutrino : 0;
		b = it.bin_index;
		corr = 65536;
		sat = 0;
		for (int s = 0; s < NSYST; s++) begin
			x = shift_tab[s];
			if (x == 0) continue;
			A = 0; B = 0; C = 0; D = 0;
			d = x - longint'(origin) * 4096;
			seg = d < 0 ? 0 : int'(d >>> 12);
			if (seg > n - 2) seg = n - 2;
			dx = x - (longint'(origin) + seg) * 4096;
			if (n == 2) begin
				y0 = smp(s, c, g, b, 0); y1 = smp(s, c, g, b, 1);
				C = 2 * (y1 - y0); D = 2 * y0;
			end else if (seg == 0) begin
				y0 = smp(s, c, g, b, 0); y1 = smp(s, c, g, b, 1); y2 = smp(s, c, g, b, 2);
				B = y0 - 2 * y1 + y2; C = -3 * y0 + 4 * y1 - y2; D = 2 * y0;
			end else if (seg == n - 2) begin
				y0 = smp(s, c, g, b, seg - 1); y1 = smp(s, c, g, b, seg);
				y2 = smp(s, c, g, b, seg + 1);
				B = y0 - 2 * y1 + y2; C = y2 - y0; D = 2 * y1;
			end else begin
				y0 = smp(s, c, g, b, seg - 1); y1 = smp(s, c, g, b, seg);
				y2 = smp(s, c, g, b, seg + 1); y3 = smp(s, c, g, b, seg + 2);
				A = -y0 + 3 * y1 - 3 * y2 + y3;
				B = 2 * y0 - 5 * y1 + 4 * y2 - y3;
				C = y2 - y0; D = 2 * y1;
			end
			acc = fshr(A * dx, 12) + B;
			acc = fshr(acc * dx, 12) + C;
			acc = fshr(acc * dx, 12) + D;
			v = clampq(acc * 2, sat);
			corr = clampq(fshr(corr * v, 16), sat);
		end
		if (corr < 0) corr = 0;
		res = (64'(it.nominal_value) * 64'(corr)) >> 16;
		if (res > 64'hFFFF_FFFF) begin
			res = 64'hFFFF_FFFF;
			sat = 1;
		end
		r.shifted_value = res[31:0];
		r.out_bin_index = it.bin_index;
		r.saturated = sat;
		return r;
	endfunction

	function automatic void apply_item(srb_in_t it);
		int c;
		c = it.component >= NUM_COMPONENTS ? NUM_COMPONENTS - 1 : it.component;
		case (it.kind)
			KIND_LOAD: begin
				if (it.point_index < NPT) begin
					ratio_tab[it.syst_index][c][it.antineutrino][it.bin_index][it.point_index] =
						it.sample_ratio > RATIO_CAP ? RATIO_CAP : it.sample_ratio;
					ratio_set[it.syst_index][c][it.antineutrino][it.bin_index][it.point_index] = 1;
				end
			end
			KIND_SHIFT: shift_tab[it.syst_index] = it.shift_value;
			KIND_BIN: expected_bins.insert(expected_bins.size(), predict_bin(it));
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(99) < idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bins.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: value %h bin %0d sat %0d",
						out_data.shifted_value, out_data.out_bin_index, out_data.saturated);
			end else begin
				srb_out_t e;
				e = expected_bins.pop_front();
				bins_checked++;
				if (e !== out_data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("bin mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
							e.shifted_value, e.out_bin_index, e.saturated,
							out_data.shifted_value, out_data.out_bin_index, out_data.saturated);
				end
			end
		end
	end

	task automatic send_item(srb_in_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		apply_item(it);
		items_sent++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (expected_bins.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (300) @(posedge clk);
	endtask

	task automatic write_cfg(logic [2:0] idx, logic [2:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_NUM_POINTS:  pt_count = val;
			CFG_FIRST_SHIFT: origin = $signed(val);
			CFG_SPLIT:       by_sign = val[0];
			default: ;
		endcase
	endtask

	function automatic srb_in_t blank_item(logic [1:0] k);
		srb_in_t it;
		it = '0;
		it.kind = k;
		it.nominal_value = $urandom;
		it.sample_ratio = 16'($urandom);
		it.shift_value = 16'($urandom);
		it.point_index = 3'($urandom_range(7));
		it.syst_index = 4'($urandom);
		it.component = 3'($urandom);
		it.antineutrino = 1'($urandom);
		it.bin_index = 6'($urandom);
		return it;
	endfunction

	// fill every point of a table so reads are always defined
	task automatic load_table(int s, int c, int g, int b, bit wild);
		srb_in_t it;
		for (int p = 0; p < NPT; p++) begin
			it = blank_item(KIND_LOAD);
			it.syst_index = 4'(s);
			it.component = 3'(c);
			it.antineutrino = 1'(g);
			it.bin_index = 6'(b);
			it.point_index = 3'(p);
			it.sample_ratio = wild ? 16'($urandom) : 16'(14000 + $urandom_range(5000));
			send_item(it);
		end
	endtask

	function automatic bit bin_ready(int c, int g, int b);
		for (int s = 0; s < NSYST; s++)
			if (shift_tab[s] != 0)
				for (int p = 0; p < NPT; p++)
					if (!ratio_set[s][c][g][b][p]) return 0;
		return 1;
	endfunction

	task automatic request_bin(int c, int b, bit anti, logic [31:0] nom);
		srb_in_t it;
		int cc;
		cc = c >= NUM_COMPONENTS ? NUM_COMPONENTS - 1 : c;
		if (!bin_ready(cc, by_sign ? anti : 0, b)) return;
		it = blank_item(KIND_BIN);
		it.component = 3'(c);
		it.antineutrino = anti;
		it.bin_index = 6'(b);
		it.nominal_value = nom;
		send_item(it);
	endtask

	task automatic set_shift(int s, logic signed [15:0] v);
		srb_in_t it;
		it = blank_item(KIND_SHIFT);
		it.syst_index = 4'(s);
		it.shift_value = v;
		send_item(it);
	endtask

	task automatic test_directed();
		srb_in_t it;
		for (int s = 0; s < 2; s++)
			for (int g = 0; g < 2; g++)
				load_table(s, 4, g, 63, s == 1);
		request_bin(7, 63, 1, 32'hFFFF_FFFF);
		set_shift(0, 16'sh1800);
		set_shift(1, -16'sh7000);
		request_bin(4, 63, 0, 32'hFFFF_FFFF);
		request_bin(6, 63, 1, 32'd0);
		set_shift(0, 16'sh7FFF);
		set_shift(1, -16'sh8000);
		request_bin(4, 63, 1, 32'h8000_0000);
		it = blank_item(KIND_RSVD);
		send_item(it);
		set_shift(0, 16'sh0000);
		set_shift(1, 16'sh0000);
	endtask

	task automatic test_random(int count, int nsyst, int nbins);
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(99);
			if (kind < 30)
				load_table($urandom_range(nsyst - 1), $urandom_range(7), $urandom_range(1),
					$urandom_range(nbins - 1), $urandom_range(9) == 0);
			else if (kind < 45)
				set_shift($urandom_range(nsyst - 1),
					$urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(32767) - 16384));
			else if (kind < 48)
				send_item(blank_item(KIND_RSVD));
			else
				request_bin($urandom_range(7), $urandom_range(nbins - 1), 1'($urandom_range(1)),
					$urandom_range(3) == 0 ? 32'($urandom) : 32'($urandom_range(1000000)));
		end
	endtask

	task automatic test_configs();
		write_cfg(CFG_NUM_POINTS, 3'd2);
		write_cfg(CFG_FIRST_SHIFT, 3'd0);
		write_cfg(CFG_SPLIT, 3'd1);
		test_random(40, 3, 2);
		write_cfg(CFG_NUM_POINTS, 3'd0);
		write_cfg(CFG_FIRST_SHIFT, 3'b100);
		test_random(30, 3, 2);
		write_cfg(CFG_NUM_POINTS, 3'd4);
		write_cfg(CFG_FIRST_SHIFT, 3'b111);
		write_cfg(CFG_SPLIT, 3'd0);
		idle_pct = 0;
		test_random(60, 4, 2);
		idle_pct = 29;
		write_cfg(CFG_NUM_POINTS, 3'd7);
		write_cfg(CFG_FIRST_SHIFT, 3'b101);
		test_random(45, 16, 64);
		write_cfg(CFG_NUM_POINTS, 3'd3);
		write_cfg(CFG_FIRST_SHIFT, 3'b110);
		write_cfg(CFG_SPLIT, 3'd1);
		test_random(60, 3, 2);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
		pt_count = 7; origin = -3; by_sign = 0;
		mismatches = 0; bins_checked = 0; items_sent = 0; idle_pct = 29;
		foreach (shift_tab[s]) shift_tab[s] = '0;
		foreach (ratio_set[a, b, c, d, e]) ratio_set[a][b][c][d][e] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(60, 4, 3);
		drain();
		test_configs();
		drain();
		$display("sent %0d items, checked %0d bin results across point, origin and split settings",
			items_sent, bins_checked);
		if (mismatches == 0 && expected_bins.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
